// ----- rtl/tccw_pkg.sv -----
package tccw_pkg;

  typedef enum logic [1:0] {
    ModeWrite     = 2'd0,
    ModeSetCursor = 2'd1,
    ModeClear     = 2'd2,
    ModeRead      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StScroll,
    StClear,
    StResp
  } state_e;

  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  localparam logic [6:0] ColumnsReset = 7'd40;
  localparam logic [5:0] RowsReset    = 6'd25;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharSpace = 8'h20;

endpackage

// ----- rtl/text_console_cell_writer.sv -----
// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
// command   in         in_valid_i/in_ready_o   mode_i, char_code_i, target_col_i, target_row_i
// result    out        out_valid_o/out_ready_i cursor_col_o, cursor_row_o, cell_data_o, scrolled_o
//
// A command issues its cell write or read in the accepting cycle; the result is registered into
// the output register in StResp once that register is free. A scroll walks every cell of the
// screen rows, as the single write port of the cell memory moves each row up and zeroes the last.
// A clear, and the pass that follows reset, zero all 2**clog2(MAX_COLUMNS) * 2**clog2(MAX_ROWS)
// cells, during which no command is accepted; configuration writes are taken throughout.
// A command may be accepted while the previous result still waits in the output register.
module text_console_cell_writer #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] target_col_i,
  input  logic [4:0] target_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic [7:0] cell_data_o,
  output logic       scrolled_o
);

  import tccw_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int Depth = 2 ** AW;
  localparam int CNW   = CW + 1;
  localparam int RNW   = RW + 1;

  function automatic logic [CNW-1:0] eff_cols(input logic [6:0] v);
    logic [CNW-1:0] e;
    if (v == '0) begin
      e = CNW'(1);
    end else if (int'(v) > MAX_COLUMNS) begin
      e = CNW'(MAX_COLUMNS);
    end else begin
      e = CNW'(v);
    end
    return e;
  endfunction

  function automatic logic [RNW-1:0] eff_rows(input logic [5:0] v);
    logic [RNW-1:0] e;
    if (v == '0) begin
      e = RNW'(1);
    end else if (int'(v) > MAX_ROWS) begin
      e = RNW'(MAX_ROWS);
    end else begin
      e = RNW'(v);
    end
    return e;
  endfunction

  state_e state_q, state_d;

  logic [6:0]    columns_q, columns_d;
  logic [5:0]    rows_q, rows_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic          scr_q, scr_d;
  logic          rd_hit_q, rd_hit_d;
  logic [RW-1:0] scan_row_q, scan_row_d;
  logic [CW-1:0] scan_col_q, scan_col_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q;
  logic          wr_zero_q;
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [5:0]    out_col_q;
  logic [4:0]    out_row_q;
  logic [7:0]    out_data_q;
  logic          out_scr_q;

  logic [CNW-1:0] ec, new_ec;
  logic [RNW-1:0] er, new_er;
  logic           in_fire;
  logic           scan_bottom, scan_end, clr_end;
  logic           cmd_we, cmd_re, go_scroll, go_clear;
  logic [AW-1:0]  cmd_waddr, cmd_raddr;
  logic [7:0]     cmd_wdata;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign ec      = eff_cols(columns_q);
  assign er      = eff_rows(rows_q);
  assign new_ec  = eff_cols(columns_d);
  assign new_er  = eff_rows(rows_d);
  assign in_fire = in_valid_i && in_ready_o;

  assign scan_bottom = int'(scan_row_q) == int'(er) - 1;
  assign scan_end    = scan_bottom && (&scan_col_q);
  assign clr_end     = &clr_addr_q;

  always_comb begin
    columns_d = columns_q;
    rows_d    = rows_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgColumns: columns_d = cfg_wdata_i;
        CfgRows:    rows_d    = cfg_wdata_i[5:0];
        default:    columns_d = columns_q;
      endcase
    end
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    scr_d     = scr_q;
    rd_hit_d  = rd_hit_q;
    cmd_we    = 1'b0;
    cmd_waddr = {cur_row_q, cur_col_q};
    cmd_wdata = CharSpace;
    cmd_re    = 1'b0;
    cmd_raddr = {RW'(target_row_i), CW'(target_col_i)};
    go_scroll = 1'b0;
    go_clear  = 1'b0;
    if (in_fire) begin
      scr_d    = 1'b0;
      rd_hit_d = 1'b0;
      unique case (mode_i)
        ModeWrite: begin
          unique case (char_code_i)
            CharLf: begin
              if (int'(cur_row_q) + 1 >= int'(er)) begin
                cur_row_d = RW'(er - 1'b1);
                go_scroll = 1'b1;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end
            CharCr: begin
              cur_col_d = '0;
            end
            CharBs: begin
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - 1'b1;
                cmd_we    = 1'b1;
                cmd_waddr = {cur_row_q, cur_col_q - 1'b1};
              end else if (cur_row_q != '0) begin
                cur_col_d = CW'(ec - 1'b1);
                cur_row_d = cur_row_q - 1'b1;
                cmd_we    = 1'b1;
                cmd_waddr = {cur_row_q - 1'b1, CW'(ec - 1'b1)};
              end
            end
            default: begin
              cmd_we    = 1'b1;
              cmd_wdata = char_code_i;
              if (int'(cur_col_q) + 1 >= int'(ec)) begin
                cur_col_d = '0;
                if (int'(cur_row_q) + 1 >= int'(er)) begin
                  cur_row_d = RW'(er - 1'b1);
                  go_scroll = 1'b1;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end
          endcase
        end
        ModeSetCursor: begin
          cur_col_d = (int'(target_col_i) >= int'(ec)) ? CW'(ec - 1'b1) : CW'(target_col_i);
          cur_row_d = (int'(target_row_i) >= int'(er)) ? RW'(er - 1'b1) : RW'(target_row_i);
        end
        ModeClear: begin
          cur_col_d = '0;
          cur_row_d = '0;
          go_clear  = 1'b1;
        end
        ModeRead: begin
          if ((int'(target_col_i) < int'(ec)) && (int'(target_row_i) < int'(er))) begin
            rd_hit_d = 1'b1;
            cmd_re   = 1'b1;
          end
        end
        default: cur_col_d = cur_col_q;
      endcase
      scr_d = go_scroll;
    end else if (cfg_we_i) begin
      if (int'(cur_col_q) >= int'(new_ec)) begin
        cur_col_d = CW'(new_ec - 1'b1);
      end
      if (int'(cur_row_q) >= int'(new_er)) begin
        cur_row_d = RW'(new_er - 1'b1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StInit: begin
        if (clr_end) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (go_clear) begin
          state_d = StClear;
        end else if (go_scroll) begin
          state_d = StScroll;
        end else if (in_fire) begin
          state_d = StResp;
        end
      end
      StScroll: begin
        if (scan_end) begin
          state_d = StResp;
        end
      end
      StClear: begin
        if (clr_end) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StInit;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == StIdle;
    out_load    = (state_q == StResp) && (!out_valid_q || out_ready_i);
    out_valid_d = out_load || (out_valid_q && !out_ready_i);

    wr_pend_d  = state_q == StScroll;
    scan_col_d = '0;
    scan_row_d = '0;
    if (state_q == StScroll) begin
      scan_col_d = scan_col_q + 1'b1;
      scan_row_d = (&scan_col_q) ? scan_row_q + 1'b1 : scan_row_q;
    end
    clr_addr_d = ((state_q == StInit) || (state_q == StClear)) ? clr_addr_q + 1'b1 : '0;

    ram_we    = 1'b0;
    ram_waddr = cmd_waddr;
    ram_wdata = cmd_wdata;
    priority if (wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = wr_zero_q ? '0 : ram_rdata;
    end else if ((state_q == StInit) || (state_q == StClear)) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (cmd_we) begin
      ram_we = 1'b1;
    end

    ram_re    = cmd_re;
    ram_raddr = cmd_raddr;
    if ((state_q == StScroll) && !scan_bottom) begin
      ram_re    = 1'b1;
      ram_raddr = {scan_row_q + 1'b1, scan_col_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      columns_q   <= ColumnsReset;
      rows_q      <= RowsReset;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      scr_q       <= 1'b0;
      rd_hit_q    <= 1'b0;
      scan_row_q  <= '0;
      scan_col_q  <= '0;
      clr_addr_q  <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      columns_q   <= columns_d;
      rows_q      <= rows_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      scr_q       <= scr_d;
      rd_hit_q    <= rd_hit_d;
      scan_row_q  <= scan_row_d;
      scan_col_q  <= scan_col_d;
      clr_addr_q  <= clr_addr_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= {scan_row_q, scan_col_q};
    wr_zero_q <= scan_bottom;
    if (out_load) begin
      out_col_q  <= 6'(cur_col_q);
      out_row_q  <= 5'(cur_row_q);
      out_data_q <= rd_hit_q ? ram_rdata : '0;
      out_scr_q  <= scr_q;
    end
  end

  tccw_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_data_o  = out_data_q;
  assign scrolled_o   = out_scr_q;

endmodule

// ----- rtl/tccw_ram.sv -----
module tccw_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
